[src/datt_pkg.sv]
`default_nettype none
package datt_pkg;
  localparam int unsigned DELIVERY_SLOTS = 16;
  localparam int unsigned ACK_QUEUE_DEPTH = 16;
  localparam int unsigned SLOT_W = $clog2(DELIVERY_SLOTS);
  localparam int unsigned ACKQ_W = $clog2(ACK_QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(ACK_QUEUE_DEPTH + 1);
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [2:0] {
    FUNC_SEND  = 3'd0,
    FUNC_RECV  = 3'd1,
    FUNC_ACK   = 3'd2,
    FUNC_SWEEP = 3'd3,
    FUNC_FLUSH = 3'd4,
    FUNC_CLEAR = 3'd5
  } func_t;

  typedef enum logic [3:0] {
    RK_SENT     = 4'd0,
    RK_FULL     = 4'd1,
    RK_IN_ORDER = 4'd2,
    RK_OUT_ORD  = 4'd3,
    RK_ACKED    = 4'd4,
    RK_UNKNOWN  = 4'd5,
    RK_TIMEOUT  = 4'd6,
    RK_SWEEP_DN = 4'd7,
    RK_ACK_HDR  = 4'd8,
    RK_ACK_ENT  = 4'd9,
    RK_CLEARED  = 4'd10
  } rkind_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] seq_value;
    logic [31:0] now_time;
  } cmd_t;
endpackage
`default_nettype wire

[src/datt_if.sv]
`default_nettype none
interface datt_in_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] seq_value;
  logic [31:0] now_time;
  modport source (output valid, func, seq_value, now_time, input ready);
  modport sink (input valid, func, seq_value, now_time, output ready);
endinterface

interface datt_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [3:0]  result_kind;
  logic [31:0] seq_out;
  logic [4:0]  ack_total;
  logic        ack_dropped;
  logic        last;
  modport source (output valid, result_kind, seq_out, ack_total, ack_dropped, last,
                  input ready);
  modport sink (input valid, result_kind, seq_out, ack_total, ack_dropped, last,
                output ready);
endinterface
`default_nettype wire

[src/datt_front.sv]
`default_nettype none
module datt_front
  import datt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  datt_in_if.sink   in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_pop
);
  localparam int unsigned PW = $clog2(CMDQ_DEPTH);
  cmd_t          q_r [CMDQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          legal, push;

  // unused codes are dropped here
  assign legal = (in_ch.func <= 3'(FUNC_CLEAR));
  assign in_ch.ready = (cnt_r != (PW+1)'(CMDQ_DEPTH));
  assign push = in_ch.valid && in_ch.ready && legal;
  assign cmd = q_r[rp_r];
  assign cmd_valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{func: func_t'(in_ch.func), seq_value: in_ch.seq_value,
                     now_time: in_ch.now_time};
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (cmd_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(cmd_pop);
    end
  end
endmodule
`default_nettype wire

[src/datt_back.sv]
`default_nettype none
module datt_back
  import datt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_pop,
  datt_out_if.source       out_ch
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH, S_EMIT} st_t;

  st_t               st_r;
  cmd_t              c_r;
  logic [31:0]       tmo_r, nout_r, nin_r;
  logic [31:0]       sseq_r [DELIVERY_SLOTS];
  logic [31:0]       stime_r [DELIVERY_SLOTS];
  logic [DELIVERY_SLOTS-1:0] sval_r;
  logic [31:0]       ackq_r [ACK_QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W:0]   idx_r;
  logic [FILL_W-1:0] fidx_r;
  logic              found_r;
  logic [SLOT_W-1:0] free_idx;
  logic              has_free;
  logic [SLOT_W-1:0] si;
  logic [31:0]       age;
  logic              ovalid_r, olast_r, odrop_r;
  logic [3:0]        okind_r;
  logic [31:0]       oseq_r;
  logic [4:0]        otot_r;
  logic              ofree;
  logic              oload;

  assign ofree = !ovalid_r || out_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.result_kind = okind_r;
  assign out_ch.seq_out = oseq_r;
  assign out_ch.ack_total = otot_r;
  assign out_ch.ack_dropped = odrop_r;
  assign out_ch.last = olast_r;
  assign si = idx_r[SLOT_W-1:0];
  assign age = c_r.now_time - stime_r[si];

  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = DELIVERY_SLOTS - 1; i >= 0; i--) begin
      if (!sval_r[i]) begin
        free_idx = SLOT_W'(i);
        has_free = 1'b1;
      end
    end
  end

  assign cmd_pop = (st_r == S_IDLE) && cmd_valid && ofree;

  // a new result enters the output register this cycle
  always_comb begin
    oload = 1'b0;
    unique case (st_r)
      S_IDLE: oload = cmd_pop && (cmd.func != FUNC_ACK) && (cmd.func != FUNC_SWEEP);
      S_SCAN: oload = ofree && (idx_r == (SLOT_W+1)'(DELIVERY_SLOTS) || found_r ||
                                (c_r.func != FUNC_ACK && sval_r[si] && age >= tmo_r));
      S_FLUSH: oload = ofree;
      default: oload = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      tmo_r <= TIMEOUT_RESET;
      nout_r <= '0;
      nin_r <= '0;
      sval_r <= '0;
      fill_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) tmo_r <= cfg_wdata;
      ovalid_r <= oload || (ovalid_r && !out_ch.ready);
      unique case (st_r)
        S_IDLE: begin
          if (cmd_pop) begin
            c_r <= cmd;
            idx_r <= '0;
            fidx_r <= '0;
            found_r <= 1'b0;
            unique case (cmd.func)
              FUNC_SEND: begin
                okind_r <= has_free ? RK_SENT : RK_FULL;
                oseq_r <= nout_r;
                otot_r <= '0;
                odrop_r <= 1'b0;
                olast_r <= 1'b1;
                if (has_free) begin
                  sval_r[free_idx] <= 1'b1;
                  sseq_r[free_idx] <= nout_r;
                  stime_r[free_idx] <= cmd.now_time;
                  nout_r <= nout_r + 32'd1;
                end
              end
              FUNC_RECV: begin
                okind_r <= (cmd.seq_value == nin_r) ? RK_IN_ORDER : RK_OUT_ORD;
                oseq_r <= cmd.seq_value;
                otot_r <= '0;
                odrop_r <= !(fill_r < FILL_W'(ACK_QUEUE_DEPTH));
                olast_r <= 1'b1;
                if (cmd.seq_value == nin_r) nin_r <= nin_r + 32'd1;
                if (fill_r < FILL_W'(ACK_QUEUE_DEPTH)) begin
                  ackq_r[fill_r[ACKQ_W-1:0]] <= cmd.seq_value;
                  fill_r <= fill_r + 1'b1;
                end
              end
              FUNC_FLUSH: begin
                okind_r <= RK_ACK_HDR;
                oseq_r <= '0;
                otot_r <= 5'(fill_r);
                odrop_r <= 1'b0;
                olast_r <= (fill_r == '0);
                if (fill_r != '0) st_r <= S_FLUSH;
              end
              FUNC_CLEAR: begin
                okind_r <= RK_CLEARED;
                oseq_r <= '0;
                otot_r <= '0;
                odrop_r <= 1'b0;
                olast_r <= 1'b1;
                sval_r <= '0;
                fill_r <= '0;
              end
              default: begin
                otot_r <= '0;
                odrop_r <= 1'b0;
                st_r <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ofree) begin
            if (idx_r == (SLOT_W+1)'(DELIVERY_SLOTS) || found_r) begin
              olast_r <= 1'b1;
              oseq_r <= (c_r.func == FUNC_ACK) ? c_r.seq_value : 32'd0;
              if (c_r.func == FUNC_ACK) begin
                okind_r <= found_r ? RK_ACKED : RK_UNKNOWN;
              end else begin
                okind_r <= RK_SWEEP_DN;
              end
              st_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
              if (c_r.func == FUNC_ACK) begin
                if (sval_r[si] && sseq_r[si] == c_r.seq_value) begin
                  sval_r[si] <= 1'b0;
                  found_r <= 1'b1;
                end
              end else if (sval_r[si] && age >= tmo_r) begin
                sval_r[si] <= 1'b0;
                okind_r <= RK_TIMEOUT;
                oseq_r <= sseq_r[si];
                olast_r <= 1'b0;
              end
            end
          end
        end
        S_FLUSH: begin
          if (ofree) begin
            okind_r <= RK_ACK_ENT;
            otot_r <= '0;
            oseq_r <= ackq_r[fidx_r[ACKQ_W-1:0]];
            fidx_r <= fidx_r + 1'b1;
            olast_r <= (fidx_r + 1'b1 == fill_r);
            if (fidx_r + 1'b1 == fill_r) begin
              fill_r <= '0;
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/delivery_ack_timeout_tracker_unit.sv]
`default_nettype none
// Tracks pending deliveries (16 slots) and a 16-entry ack queue. A two-entry
// command queue decouples intake from execution, so an accepted transaction
// is registered in the queue before the executor sees it. Send, receive and
// clear complete at dispatch. An ack match walks the slots one per cycle while
// the output is free and stops at the first hit; a timeout sweep always walks
// all 16; either runs as dispatch, one step per slot, then the final result.
// A flush emits a header and then one entry per queued ack. Every step that
// emits a result waits while the output register holds an unaccepted result.
// Unused function codes are dropped at intake with no result.
module delivery_ack_timeout_tracker_unit
  import datt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  datt_in_if.sink          in_ch,
  datt_out_if.source       out_ch
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  datt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  datt_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

[tb/delivery_ack_timeout_tracker_checker.sv]
`timescale 1ns / 1ps
module delivery_ack_timeout_tracker_checker
  import datt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  datt_in_if               in_ch,
  datt_out_if              out_ch,
  output int               fail_count,
  output int               pending_count
);
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] seq;
    logic [4:0]  total;
    logic        dropped;
    logic        last;
  } tracker_result_t;

  tracker_result_t expected_results[$];
  logic [31:0] timeout_reg;
  logic [31:0] out_seq_ctr;
  logic [31:0] in_seq_ctr;
  logic [31:0] pend_seq [DELIVERY_SLOTS];
  logic [31:0] pend_time [DELIVERY_SLOTS];
  logic        pend_live [DELIVERY_SLOTS];
  logic [31:0] ack_queue [ACK_QUEUE_DEPTH];
  int          ack_count;

  function automatic tracker_result_t mk(logic [3:0] k, logic [31:0] s, logic [4:0] t,
                                         logic d, logic l);
    tracker_result_t r;
    r.kind = k; r.seq = s; r.total = t; r.dropped = d; r.last = l;
    return r;
  endfunction

  task automatic expect_result(logic [3:0] k, logic [31:0] s, logic [4:0] t,
                               logic d, logic l);
    expected_results.insert(expected_results.size(), mk(k, s, t, d, l));
  endtask

  task automatic report(string what, tracker_result_t got, tracker_result_t exp_r);
    $display("ERROR %0t: %s got k=%0d s=%0h t=%0d d=%0b l=%0b exp k=%0d s=%0h t=%0d d=%0b l=%0b",
             $realtime, what, got.kind, got.seq, got.total, got.dropped, got.last,
             exp_r.kind, exp_r.seq, exp_r.total, exp_r.dropped, exp_r.last);
    fail_count++;
  endtask

  task automatic track_transaction(logic [2:0] fn, logic [31:0] sv, logic [31:0] nt);
    int i;
    case (fn)
      FUNC_SEND: begin
        for (i = 0; i < DELIVERY_SLOTS; i++) if (!pend_live[i]) break;
        if (i == DELIVERY_SLOTS) begin
          expect_result(RK_FULL, out_seq_ctr, 5'd0, 1'b0, 1'b1);
        end else begin
          pend_live[i] = 1; pend_seq[i] = out_seq_ctr; pend_time[i] = nt;
          expect_result(RK_SENT, out_seq_ctr, 5'd0, 1'b0, 1'b1);
          out_seq_ctr = out_seq_ctr + 1;
        end
      end
      FUNC_RECV: begin
        logic match, drop;
        match = (sv == in_seq_ctr);
        drop = 0;
        if (match) in_seq_ctr = in_seq_ctr + 1;
        if (ack_count < ACK_QUEUE_DEPTH) begin
          ack_queue[ack_count] = sv; ack_count++;
        end else begin
          drop = 1;
        end
        expect_result(match ? RK_IN_ORDER : RK_OUT_ORD, sv, 5'd0, drop, 1'b1);
      end
      FUNC_ACK: begin
        for (i = 0; i < DELIVERY_SLOTS; i++) if (pend_live[i] && pend_seq[i] == sv) break;
        if (i == DELIVERY_SLOTS) begin
          expect_result(RK_UNKNOWN, sv, 5'd0, 1'b0, 1'b1);
        end else begin
          pend_live[i] = 0;
          expect_result(RK_ACKED, sv, 5'd0, 1'b0, 1'b1);
        end
      end
      FUNC_SWEEP: begin
        for (i = 0; i < DELIVERY_SLOTS; i++) begin
          if (pend_live[i] && (nt - pend_time[i]) >= timeout_reg) begin
            pend_live[i] = 0;
            expect_result(RK_TIMEOUT, pend_seq[i], 5'd0, 1'b0, 1'b0);
          end
        end
        expect_result(RK_SWEEP_DN, 32'd0, 5'd0, 1'b0, 1'b1);
      end
      FUNC_FLUSH: begin
        expect_result(RK_ACK_HDR, 32'd0, ack_count[4:0], 1'b0, ack_count == 0);
        for (i = 0; i < ack_count; i++)
          expect_result(RK_ACK_ENT, ack_queue[i], 5'd0, 1'b0, i + 1 == ack_count);
        ack_count = 0;
      end
      FUNC_CLEAR: begin
        for (i = 0; i < DELIVERY_SLOTS; i++) pend_live[i] = 0;
        ack_count = 0;
        expect_result(RK_CLEARED, 32'd0, 5'd0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    tracker_result_t got, exp_r;
    if (!rst_n) begin
      timeout_reg <= TIMEOUT_RESET;
      out_seq_ctr = 0;
      in_seq_ctr = 0;
      ack_count = 0;
      for (int i = 0; i < DELIVERY_SLOTS; i++) pend_live[i] = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) timeout_reg <= cfg_wdata;
      if (in_ch.valid && in_ch.ready) track_transaction(in_ch.func, in_ch.seq_value, in_ch.now_time);
      if (out_ch.valid && out_ch.ready) begin
        got = mk(out_ch.result_kind, out_ch.seq_out, out_ch.ack_total, out_ch.ack_dropped,
                 out_ch.last);
        if (expected_results.size() == 0) begin
          report("unexpected", got, got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) report("mismatch", got, exp_r);
        end
      end
    end
    pending_count = expected_results.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end
endmodule

[tb/delivery_ack_timeout_tracker_unit_test.sv]
`timescale 1ns / 1ps
module delivery_ack_timeout_tracker_unit_test;
  import datt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending_count;
  int          cycle_count;
  int          stall_phase;
  int          burst_left;
  int          gap_left;
  logic [31:0] send_clock;
  logic [31:0] recv_next;

  datt_in_if  in_ch (clk);
  datt_out_if out_ch (clk);

  delivery_ack_timeout_tracker_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  delivery_ack_timeout_tracker_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stall pattern: runs of ready, random stalls, some free-flowing stretches
  initial begin
    out_ch.ready = 0;
    stall_phase = 0;
    forever begin
      @(posedge clk);
      stall_phase++;
      if (stall_phase % 400 < 100) out_ch.ready <= 1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0) || ((stall_phase / 7) % 3 == 0);
    end
  end

  task automatic send_item(logic [2:0] fn, logic [31:0] sv, logic [31:0] nt);
    if (gap_left > 0) begin
      in_ch.valid <= 0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_ch.valid <= 1;
    in_ch.func <= fn;
    in_ch.seq_value <= sv;
    in_ch.now_time <= nt;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  task automatic drain_and_config(logic [31:0] value);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count);
    int  pick;
    logic [31:0] sv;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      send_clock = send_clock + $urandom_range(0, 300);
      if (pick < 30) send_item(FUNC_SEND, 0, send_clock);
      else if (pick < 50) begin
        sv = ($urandom_range(0, 3) != 0) ? recv_next : $urandom;
        if (sv == recv_next) recv_next = recv_next + 1;
        send_item(FUNC_RECV, sv, 0);
      end else if (pick < 70) begin
        sv = ($urandom_range(0, 4) != 0) ? chk.out_seq_ctr - $urandom_range(1, 20) : $urandom;
        send_item(FUNC_ACK, sv, 0);
      end else if (pick < 82) send_item(FUNC_SWEEP, 0, send_clock + $urandom_range(0, 3000));
      else if (pick < 92) send_item(FUNC_FLUSH, $urandom, $urandom);
      else if (pick < 95) send_item(FUNC_CLEAR, 0, 0);
      else if (pick < 97) send_item(3'($urandom_range(6, 7)), $urandom, $urandom);
      else send_item(FUNC_SWEEP, 0, $urandom);
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.func = FUNC_SEND;
    in_ch.seq_value = 0;
    in_ch.now_time = 0;
    burst_left = 4;
    gap_left = 0;
    send_clock = 0;
    recv_next = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fill table, full, acks incl. unknown, queue overflow, flush, sweep
    for (int i = 0; i < 17; i++) send_item(FUNC_SEND, 0, 32'hFFFF_FF00);
    send_item(FUNC_ACK, 3, 0);
    send_item(FUNC_ACK, 32'hFFFF_FFFF, 0);
    send_item(FUNC_SWEEP, 0, 32'h0000_0100);
    for (int i = 0; i < 17; i++) send_item(FUNC_RECV, (i == 5) ? 32'hFFFF_FFFF : i, 0);
    send_item(FUNC_FLUSH, 0, 0);
    send_item(FUNC_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_SWEEP, 0, 32'h0000_0400);
    recv_next = 16;
    send_item(FUNC_CLEAR, 0, 0);

    drain_and_config(0);
    send_item(FUNC_SEND, 0, 32'h1234_5678);
    send_item(FUNC_SWEEP, 0, 32'h1234_5678);
    random_phase(20);

    drain_and_config(32'hFFFF_FFFF);
    random_phase(15);
    send_item(FUNC_SWEEP, 0, send_clock - 1);

    drain_and_config(1);
    random_phase(15);

    drain_and_config(1500);
    random_phase(14);
    send_item(FUNC_FLUSH, 0, 0);

    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[tb/datt_tb_note.sv]
`timescale 1ns / 1ps
